[hdl/swdr_pkg.sv]
// Shared types and constants for the stack with duplicate removal.
`timescale 1ns / 1ps

package swdr_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Address source for read port A of the entry memory.
    typedef enum logic [1:0] {
        RSEL_SCAN  = 2'd0,
        RSEL_SHIFT = 2'd1,
        RSEL_TOP   = 2'd2
    } t_rsel;

    typedef struct packed {
        logic  accept;
        logic  scan_next;
        logic  found;
        logic  shift_wr;
        logic  shift_end;
        logic  rd_en;
        t_rsel rsel;
        logic  out_load;
    } t_ctl;

    typedef struct packed {
        logic cnt_ge2;
        logic match;
        logic j_last;
        logic i_zero;
        logic shift_more;
        logic out_free;
    } t_sts;

endpackage

[hdl/swdr_if.sv]
// Handshake interfaces for the command channel and the result channel.
`timescale 1ns / 1ps

interface swdr_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            command;
    logic [DATA_WIDTH-1:0] data_value;

    modport source (output valid, output command, output data_value, input ready);
    modport sink   (input valid, input command, input data_value, output ready);
endinterface

interface swdr_out_if #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 5
);
    logic                   valid;
    logic                   ready;
    logic [DATA_WIDTH-1:0]  top_value;
    logic                   is_empty;
    logic [COUNT_WIDTH-1:0] fill_level;
    logic [1:0]             status;
    logic                   removed;
    logic [DATA_WIDTH-1:0]  removed_value;

    modport source (output valid, output top_value, output is_empty, output fill_level,
                    output status, output removed, output removed_value, input ready);
    modport sink   (input valid, input top_value, input is_empty, input fill_level,
                    input status, input removed, input removed_value, output ready);
endinterface

[hdl/swdr_ctrl.sv]
// Sequencing state machine for commands, duplicate scan, gap closing and result.
`timescale 1ns / 1ps

module swdr_ctrl
    import swdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_ctl       o_ctl
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CMP = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_TOP_RD   = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_ctl   = '{accept: 1'b0, scan_next: 1'b0, found: 1'b0, shift_wr: 1'b0,
                    shift_end: 1'b0, rd_en: 1'b0, rsel: RSEL_TOP, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_ctl.accept = 1'b1;
                    if (t_cmd'(i_command) == CMD_REMOVE && i_sts.cnt_ge2) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_TOP_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_ctl.rd_en = 1'b1;
                o_ctl.rsel  = RSEL_SCAN;
                n_state     = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_ctl.found = 1'b1;
                    n_state     = S_SHIFT_RD;
                end else if (i_sts.j_last && i_sts.i_zero) begin
                    n_state = S_TOP_RD;
                end else begin
                    o_ctl.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_more) begin
                    o_ctl.rd_en = 1'b1;
                    o_ctl.rsel  = RSEL_SHIFT;
                    n_state     = S_SHIFT_WR;
                end else begin
                    o_ctl.shift_end = 1'b1;
                    n_state         = S_TOP_RD;
                end
            end
            S_SHIFT_WR: begin
                o_ctl.shift_wr = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_TOP_RD: begin
                o_ctl.rd_en = 1'b1;
                o_ctl.rsel  = RSEL_TOP;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/swdr_dpath.sv]
// Entry memory, fill count, scan and shift indexes, and the result register.
`timescale 1ns / 1ps

module swdr_dpath
    import swdr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_command,
    input  logic [DATA_WIDTH-1:0] i_data_value,
    input  t_ctl                  i_ctl,
    input  logic                  i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [DATA_WIDTH-1:0] o_top_value,
    output logic                  o_is_empty,
    output logic [CW-1:0]         o_fill_level,
    output logic [1:0]            o_status,
    output logic                  o_removed,
    output logic [DATA_WIDTH-1:0] o_removed_value
);

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;

    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_i, r_j, r_k;
    t_status               r_status;
    logic                  r_removed;
    logic [DATA_WIDTH-1:0] r_removed_value;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_top;
    logic                  r_out_empty;
    logic [CW-1:0]         r_out_fill;
    t_status               r_out_status;
    logic                  r_out_removed;
    logic [DATA_WIDTH-1:0] r_out_removed_value;

    logic [CW-1:0]         w_count_m1, w_count_m2, w_k_inc, w_j_inc;
    logic [AW-1:0]         w_addr_a, w_addr_b, w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_wr_en;
    logic                  w_cnt_zero, w_full;
    t_cmd                  w_cmd;

    assign w_cmd      = t_cmd'(i_command);
    assign w_count_m1 = r_count - CW'(1);
    assign w_count_m2 = r_count - CW'(2);
    assign w_k_inc    = CW'(r_k) + CW'(1);
    assign w_j_inc    = CW'(r_j) + CW'(1);
    assign w_cnt_zero = (r_count == '0);
    assign w_full     = (r_count == DEPTH_C);

    // Read address select for the two memory read ports.
    always_comb begin
        w_addr_b = r_j;
        unique case (i_ctl.rsel)
            RSEL_SCAN:  w_addr_a = r_i;
            RSEL_SHIFT: w_addr_a = w_k_inc[AW-1:0];
            RSEL_TOP:   w_addr_a = w_count_m1[AW-1:0];
            default:    w_addr_a = r_i;
        endcase
    end

    // A push writes on top; closing the gap writes one entry down each step.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_k;
        w_wr_data = r_rd_a;
        if (i_ctl.accept && w_cmd == CMD_PUSH && !w_full) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_count[AW-1:0];
            w_wr_data = i_data_value;
        end else if (i_ctl.shift_wr) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[w_addr_a];
            r_rd_b <= r_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.accept) begin
            unique case (w_cmd)
                CMD_PUSH:   if (!w_full) r_count <= r_count + CW'(1);
                CMD_POP:    if (!w_cnt_zero) r_count <= w_count_m1;
                CMD_REMOVE: r_count <= r_count;
                CMD_CLEAR:  r_count <= '0;
                default:    r_count <= r_count;
            endcase
        end else if (i_ctl.shift_end) begin
            r_count <= w_count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_i             <= w_count_m2[AW-1:0];
            r_j             <= w_count_m1[AW-1:0];
            r_removed       <= 1'b0;
            r_removed_value <= '0;
            r_status        <= ST_OK;
            if (w_cmd == CMD_PUSH && w_full) begin
                r_status <= ST_FULL;
            end else if ((w_cmd == CMD_POP || w_cmd == CMD_REMOVE) && w_cnt_zero) begin
                r_status <= ST_EMPTY;
            end
        end else if (i_ctl.scan_next) begin
            // Once the upper index has reached the top, step the lower one down.
            if (o_sts.j_last) begin
                r_i <= r_i - AW'(1);
                r_j <= r_i;
            end else begin
                r_j <= w_j_inc[AW-1:0];
            end
        end else if (i_ctl.found) begin
            r_k             <= r_i;
            r_removed       <= 1'b1;
            r_removed_value <= r_rd_a;
        end else if (i_ctl.shift_wr) begin
            r_k <= w_k_inc[AW-1:0];
        end
    end

    // Result register: a finished result can wait here while the next command runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_top           <= w_cnt_zero ? '0 : r_rd_a;
            r_out_empty         <= w_cnt_zero;
            r_out_fill          <= r_count;
            r_out_status        <= r_status;
            r_out_removed       <= r_removed;
            r_out_removed_value <= r_removed_value;
        end
    end

    assign o_sts.cnt_ge2    = (r_count >= CW'(2));
    assign o_sts.match      = (r_rd_a == r_rd_b);
    assign o_sts.j_last     = (w_j_inc == r_count);
    assign o_sts.i_zero     = (r_i == '0);
    assign o_sts.shift_more = (w_k_inc < r_count);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_top_value     = r_out_top;
    assign o_is_empty      = r_out_empty;
    assign o_fill_level    = r_out_fill;
    assign o_status        = r_out_status;
    assign o_removed       = r_out_removed;
    assign o_removed_value = r_out_removed_value;

endmodule

[hdl/stack_with_duplicate_removal_unit.sv]
// Top level of the LIFO stack with first-duplicate removal.
//
//  channel | direction | payload                                              | transfer
//  i_in    | in        | command, data_value                                  | valid & ready
//  o_out   | out       | top_value, is_empty, fill_level, status,             | valid & ready
//          |           | removed, removed_value                               |
//
// Push, pop and clear go through accept, top-of-stack memory read and result load.
// Remove adds a memory read and a compare per pair of entries, done by the single shared
// compare on the two memory read ports; a found duplicate then adds a read and a write
// for each entry moved down, and a final step that lowers the fill count.
// Reset is synchronous and active low; it empties the stack, the memory needs no pass.
// A new command is taken while an earlier result waits; a stalled output holds the
// block only when the next result is ready to load.
`timescale 1ns / 1ps

module stack_with_duplicate_removal_unit
    import swdr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swdr_in_if.sink   i_in,
    swdr_out_if.source o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    swdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_ctl      (w_ctl)
    );

    swdr_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_in.command),
        .i_data_value    (i_in.data_value),
        .i_ctl           (w_ctl),
        .i_out_ready     (o_out.ready),
        .o_sts           (w_sts),
        .o_out_valid     (o_out.valid),
        .o_top_value     (o_out.top_value),
        .o_is_empty      (o_out.is_empty),
        .o_fill_level    (o_out.fill_level[CW-1:0]),
        .o_status        (o_out.status),
        .o_removed       (o_out.removed),
        .o_removed_value (o_out.removed_value)
    );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the LIFO stack with first-duplicate removal.
`timescale 1ns / 1ps

module testbench;
    import swdr_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int WORD_W      = DATA_WIDTH_DEF;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH_DEF + 1);
    localparam int RANDOM_OPS  = 1100;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_cmd              cmd;
        logic [WORD_W-1:0] value;
    } t_stack_op;

    typedef struct packed {
        logic [WORD_W-1:0]  top;
        logic               empty;
        logic [LEVEL_W-1:0] level;
        t_status            status;
        logic               removed;
        logic [WORD_W-1:0]  removed_val;
    } t_stack_result;

    logic i_clk;
    logic i_rst_n;

    swdr_in_if  #(.DATA_WIDTH(WORD_W))                        in_ch ();
    swdr_out_if #(.DATA_WIDTH(WORD_W), .COUNT_WIDTH(LEVEL_W)) out_ch ();

    stack_with_duplicate_removal_unit #(
        .STACK_DEPTH(DEPTH),
        .DATA_WIDTH (WORD_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predictor state: a shadow copy of the stack contents.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                shadow_fill;

    t_stack_op     cmd_backlog [$];
    t_stack_result results_due [$];
    logic [WORD_W-1:0] word_pool [6];

    int ops_total;
    int ops_accepted;
    int results_seen;
    int mismatches;
    int cycle_count;
    int cmd_counts [4];
    int dup_removals;
    int full_rejects;
    int empty_hits;
    logic steady_phase;

    // Neither side inserts gaps while this window of transfers goes by.
    assign steady_phase = (ops_accepted >= 500) && (ops_accepted < 700);

    function automatic t_stack_result apply_stack_command(t_stack_op op);
        t_stack_result r;
        int hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        cmd_counts[op.cmd]++;
        case (op.cmd)
            CMD_PUSH: begin
                if (shadow_fill == DEPTH) begin
                    r.status = ST_FULL;
                    full_rejects++;
                end else begin
                    shadow_words[shadow_fill] = op.value;
                    shadow_fill++;
                end
            end
            CMD_POP: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    shadow_fill--;
                end
            end
            CMD_REMOVE: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    // Walk down from the top; the first entry repeated above it goes.
                    for (int i = shadow_fill - 1; i >= 0 && hit < 0; i--)
                        for (int j = i + 1; j < shadow_fill && hit < 0; j++)
                            if (shadow_words[j] == shadow_words[i])
                                hit = i;
                    if (hit >= 0) begin
                        r.removed     = 1'b1;
                        r.removed_val = shadow_words[hit];
                        for (int k = hit; k + 1 < shadow_fill; k++)
                            shadow_words[k] = shadow_words[k + 1];
                        shadow_fill--;
                        dup_removals++;
                    end
                end
            end
            default: begin
                shadow_fill = 0;
            end
        endcase
        r.empty = (shadow_fill == 0);
        r.level = shadow_fill[LEVEL_W-1:0];
        r.top   = (shadow_fill == 0) ? '0 : shadow_words[shadow_fill - 1];
        return r;
    endfunction

    task automatic queue_op(t_cmd c, logic [WORD_W-1:0] v);
        t_stack_op op;
        op.cmd   = c;
        op.value = v;
        cmd_backlog.push_back(op);
    endtask

    // Mostly words from a small pool so that duplicates are common.
    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(99) < 65)
            return word_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    function automatic t_cmd pick_cmd();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return CMD_PUSH;
        if (roll < 65)
            return CMD_POP;
        if (roll < 93)
            return CMD_REMOVE;
        return CMD_CLEAR;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_clk   = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d transfers accepted",
                     cycle_count, ops_accepted, ops_total);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sender: holds each item until it is taken, then may pause before the next one.
    always @(posedge i_clk) begin
        t_stack_op nxt;
        t_stack_op taken;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                taken.cmd   = t_cmd'(in_ch.command);
                taken.value = in_ch.data_value;
                results_due.push_back(apply_stack_command(taken));
                ops_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_backlog.size() > 0 && (steady_phase || $urandom_range(99) >= 35)) begin
                    nxt = cmd_backlog.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.command    <= nxt.cmd;
                    in_ch.data_value <= nxt.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure plus one long hold-off that fills the block.
    always @(posedge i_clk) begin
        int  hold_left;
        bit  hold_done;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && ops_accepted >= 150) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady_phase || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        t_stack_result got;
        t_stack_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.top         = out_ch.top_value;
            got.empty       = out_ch.is_empty;
            got.level       = out_ch.fill_level;
            got.status      = t_status'(out_ch.status);
            got.removed     = out_ch.removed;
            got.removed_val = out_ch.removed_value;
            results_seen++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d arrived with nothing pending: top=%h level=%0d",
                             results_seen, got.top, got.level);
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d mismatch (expected / actual):", results_seen);
                        $display("  top=%h/%h empty=%b/%b level=%0d/%0d status=%0d/%0d",
                                 want.top, got.top, want.empty, got.empty,
                                 want.level, got.level, want.status, got.status);
                        $display("  removed=%b/%b removed_value=%h/%h",
                                 want.removed, got.removed, want.removed_val, got.removed_val);
                    end
                end
            end
        end
    end

    initial begin
        int made;
        int n;
        made = 0;
        shadow_fill = 0;
        word_pool[0] = '0;
        word_pool[1] = '1;
        for (int p = 2; p < 6; p++)
            word_pool[p] = $urandom;

        // Directed: empty-stack cases, a duplicate at the bottom, a search that
        // finds nothing, filling to the limit and a rejected push.
        queue_op(CMD_POP, 32'h1234_5678);
        queue_op(CMD_REMOVE, '0);
        queue_op(CMD_CLEAR, '1);
        queue_op(CMD_PUSH, '0);
        queue_op(CMD_PUSH, '1);
        queue_op(CMD_PUSH, '0);
        queue_op(CMD_REMOVE, '1);
        queue_op(CMD_REMOVE, '0);
        for (int d = 0; d < DEPTH - 2; d++)
            queue_op(CMD_PUSH, (d % 2 == 0) ? 32'h5555_5555 ^ d : 32'hAAAA_AAAA ^ d);
        queue_op(CMD_PUSH, 32'hDEAD_BEEF);
        queue_op(CMD_POP, '0);
        queue_op(CMD_CLEAR, '0);

        // Random: fill-then-scan sequences with random content, mixed with noise.
        while (made < RANDOM_OPS) begin
            if ($urandom_range(99) < 60) begin
                if ($urandom_range(1) == 1) begin
                    queue_op(CMD_CLEAR, $urandom);
                    made++;
                end
                n = $urandom_range(2, DEPTH + 2);
                for (int k = 0; k < n; k++)
                    queue_op(CMD_PUSH, pick_word());
                made += n;
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    queue_op(t_cmd'(($urandom_range(4) == 0) ? CMD_POP : CMD_REMOVE), $urandom);
                made += n;
            end else begin
                for (int k = 0; k < 20; k++)
                    queue_op(pick_cmd(), pick_word());
                made += 20;
            end
        end
        ops_total = cmd_backlog.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < ops_total)
            @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d pushes, %0d pops, %0d duplicate searches, %0d clears.",
                 cmd_counts[CMD_PUSH], cmd_counts[CMD_POP],
                 cmd_counts[CMD_REMOVE], cmd_counts[CMD_CLEAR]);
        $display("Saw %0d deletions, %0d pushes onto a full stack, %0d commands on empty.",
                 dup_removals, full_rejects, empty_hits);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
